FILE: design/xxtea_pkg.sv
// Shared constants, types and round-count table of the XXTEA block cipher.
`timescale 1ns / 1ps
package xxtea_pkg;

    localparam int MAX_BLOCK_WORDS_DEF = 16;

    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int BLEN_W    = 5;
    localparam int ROUND_W   = 6;
    localparam int NLEN_W    = 7;

    localparam logic [WORD_W-1:0] XXTEA_DELTA = 32'h9E37_79B9;

    localparam logic [BLEN_W-1:0] BLEN_RESET = 5'd16;
    localparam logic [BLEN_W-1:0] BLEN_MIN   = 5'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_FIRST,
        ST_RD_NB,
        ST_MIX,
        ST_UPDATE,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    // 6 + 52/n full rounds
    function automatic logic [ROUND_W-1:0] rounds_for(input logic [NLEN_W-1:0] n);
        logic [ROUND_W-1:0] r;
        case (n) inside
            [7'd0:7'd2]:   r = 6'd32;
            7'd3:          r = 6'd23;
            7'd4:          r = 6'd19;
            7'd5:          r = 6'd16;
            7'd6:          r = 6'd14;
            7'd7:          r = 6'd13;
            7'd8:          r = 6'd12;
            [7'd9:7'd10]:  r = 6'd11;
            [7'd11:7'd13]: r = 6'd10;
            [7'd14:7'd17]: r = 6'd9;
            [7'd18:7'd26]: r = 6'd8;
            [7'd27:7'd52]: r = 6'd7;
            default:       r = 6'd6;
        endcase
        return r;
    endfunction

endpackage

FILE: design/xxtea_block_cipher.sv
// XXTEA block cipher top level: word collection, round sequencer and result stream.
//
// Usage: 32-bit words enter on the s_ stream, lowest block index first, one per
// cycle while s_tready is high. Once block_length words (clamped to 2..MAX) are
// collected, the block is encrypted or decrypted in place with the standard XXTEA
// schedule, and the n result words leave on the m_ stream in index order, with
// m_tlast on the final word. Key, length and direction are written through the
// cfg_ channel (index 0..3 key words, 4 block length, 5 decrypt); the user must
// write them only while idle; the block does not enforce this. The rounds then
// run over the block, and the result words are read out of the RAM one at a
// time. Each word update takes three steps on the block RAM: neighbor read,
// own read, and write-back through the shared mix unit.
// s_tready is low from block completion until the last result word is loaded
// into the output register; that word may wait for m_tready while new words load.
// A stalled receiver holds the output register and pauses the result readout.
// Reset (aresetn low, synchronous) clears the configuration to key 0, length 16,
// encrypt, empties the word count and drops any pending result.
`timescale 1ns / 1ps
module xxtea_block_cipher #(
    parameter int MAX_BLOCK_WORDS = xxtea_pkg::MAX_BLOCK_WORDS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [xxtea_pkg::WORD_W-1:0]   s_tdata,   // [31:0] data_word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [xxtea_pkg::WORD_W-1:0]   m_tdata,   // [31:0] result_word
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [xxtea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [xxtea_pkg::WORD_W-1:0]   cfg_data
);

    import xxtea_pkg::*;

    localparam int AW    = $clog2(MAX_BLOCK_WORDS);
    localparam int CW    = $clog2(MAX_BLOCK_WORDS + 1);
    localparam int CMP_W = (CW > BLEN_W) ? CW : BLEN_W;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_BLOCK_WORDS);

    function automatic logic [WORD_W-1:0] mix(
        input logic [WORD_W-1:0] y,
        input logic [WORD_W-1:0] z,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] k
    );
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = (z >> 5) ^ (y << 2);
        b = (y >> 3) ^ (z << 4);
        return (a + b) ^ ((sum ^ y) + (k ^ z));
    endfunction

    state_t state_reg, state_next;

    logic [WORD_W-1:0]  key_reg [4];
    logic [WORD_W-1:0]  key_next [4];
    logic [BLEN_W-1:0]  blen_reg, blen_next;
    logic               dec_reg, dec_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      p_reg, p_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic [WORD_W-1:0]  sum_reg, sum_next;
    logic [WORD_W-1:0]  zy_reg, zy_next;
    logic [WORD_W-1:0]  mix_reg, mix_next;
    logic [AW-1:0]      out_idx_reg, out_idx_next;
    logic [WORD_W-1:0]  m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;
    logic               m_valid_reg, m_valid_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [WORD_W-1:0]  rd_data;

    logic               s_accept;
    logic [CW-1:0]      n_eff;
    logic [CW:0]        cnt_inc;
    logic               blk_done;
    logic [CW-1:0]      n_m1;
    logic               p_top;
    logic               p_zero;
    logic               round_end;
    logic [AW-1:0]      nb_addr;
    logic [ROUND_W-1:0] rounds_cur;
    logic [WORD_W-1:0]  key_sel;
    logic [WORD_W-1:0]  new_word;
    logic               out_free;
    logic               out_last;

    xxtea_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BLOCK_WORDS)
    ) u_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;

    always_comb begin
        if (blen_reg < BLEN_MIN) begin
            n_eff = CW'(BLEN_MIN);
        end else if (CMP_W'(blen_reg) > CMP_W'(MAX_N)) begin
            n_eff = MAX_N;
        end else begin
            n_eff = CW'(blen_reg);
        end
    end

    assign cnt_inc    = {1'b0, cnt_reg} + 1'b1;
    assign blk_done   = cnt_inc >= {1'b0, n_eff};
    assign n_m1       = n_reg - 1'b1;
    assign p_top      = CW'(p_reg) == n_m1;
    assign p_zero     = p_reg == '0;
    assign round_end  = dec_reg ? p_zero : p_top;
    assign rounds_cur = rounds_for(NLEN_W'(n_reg));
    assign key_sel    = key_reg[2'(p_reg) ^ sum_reg[3:2]];
    assign new_word   = dec_reg ? (rd_data - mix_reg) : (rd_data + mix_reg);
    assign out_free   = !m_valid_reg || m_tready;
    assign out_last   = CW'(out_idx_reg) == n_m1;

    always_comb begin
        if (dec_reg) begin
            nb_addr = p_zero ? AW'(n_m1) : p_reg - 1'b1;
        end else begin
            nb_addr = p_top ? '0 : p_reg + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && blk_done) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                state_next = (rounds_cur == '0) ? ST_OUT_RD : ST_FIRST;
            end
            ST_FIRST:  state_next = ST_MIX;
            ST_RD_NB:  state_next = ST_MIX;
            ST_MIX:    state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (round_end && rnd_reg == ROUND_W'(1)) begin
                    state_next = ST_OUT_RD;
                end else begin
                    state_next = ST_RD_NB;
                end
            end
            ST_OUT_RD: begin
                if (out_free) begin
                    state_next = ST_OUT_LD;
                end
            end
            ST_OUT_LD: begin
                state_next = out_last ? ST_IDLE : ST_OUT_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        key_next     = key_reg;
        blen_next    = blen_reg;
        dec_next     = dec_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        rnd_next     = rnd_reg;
        sum_next     = sum_reg;
        zy_next      = zy_reg;
        mix_next     = mix_reg;
        out_idx_next = out_idx_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_tready;
        wr_en        = 1'b0;
        wr_addr      = p_reg;
        wr_data      = new_word;
        rd_en        = 1'b0;
        rd_addr      = p_reg;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_KEY0:    key_next[0] = cfg_data;
                CFG_KEY1:    key_next[1] = cfg_data;
                CFG_KEY2:    key_next[2] = cfg_data;
                CFG_KEY3:    key_next[3] = cfg_data;
                CFG_BLEN:    blen_next   = cfg_data[BLEN_W-1:0];
                CFG_DECRYPT: dec_next    = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    wr_en   = cnt_reg < MAX_N;
                    wr_addr = AW'(cnt_reg);
                    wr_data = s_tdata;
                    if (blk_done) begin
                        cnt_next = '0;
                        n_next   = n_eff;
                    end else begin
                        cnt_next = cnt_inc[CW-1:0];
                    end
                end
            end
            ST_INIT: begin
                rd_en        = 1'b1;
                rd_addr      = dec_reg ? '0 : AW'(n_m1);
                rnd_next     = rounds_cur;
                sum_next     = dec_reg ? (WORD_W'(rounds_cur) * XXTEA_DELTA) : XXTEA_DELTA;
                p_next       = dec_reg ? AW'(n_m1) : '0;
                out_idx_next = '0;
            end
            ST_FIRST: begin
                zy_next = rd_data;
                rd_en   = 1'b1;
                rd_addr = nb_addr;
            end
            ST_RD_NB: begin
                rd_en   = 1'b1;
                rd_addr = nb_addr;
            end
            ST_MIX: begin
                mix_next = dec_reg ? mix(zy_reg, rd_data, sum_reg, key_sel)
                                   : mix(rd_data, zy_reg, sum_reg, key_sel);
                rd_en    = 1'b1;
                rd_addr  = p_reg;
            end
            ST_UPDATE: begin
                wr_en   = 1'b1;
                zy_next = new_word;
                if (round_end) begin
                    p_next   = dec_reg ? AW'(n_m1) : '0;
                    sum_next = dec_reg ? (sum_reg - XXTEA_DELTA) : (sum_reg + XXTEA_DELTA);
                    rnd_next = rnd_reg - 1'b1;
                end else begin
                    p_next = dec_reg ? (p_reg - 1'b1) : (p_reg + 1'b1);
                end
            end
            ST_OUT_RD: begin
                if (out_free) begin
                    rd_en   = 1'b1;
                    rd_addr = out_idx_reg;
                end
            end
            ST_OUT_LD: begin
                m_data_next  = rd_data;
                m_last_next  = out_last;
                m_valid_next = 1'b1;
                out_idx_next = out_idx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            key_reg     <= '{default: '0};
            blen_reg    <= BLEN_RESET;
            dec_reg     <= 1'b0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            key_reg     <= key_next;
            blen_reg    <= blen_next;
            dec_reg     <= dec_next;
            cnt_reg     <= cnt_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        p_reg       <= p_next;
        rnd_reg     <= rnd_next;
        zy_reg      <= zy_next;
        mix_reg     <= mix_next;
        out_idx_reg <= out_idx_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

endmodule

FILE: design/xxtea_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module xxtea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sim/tb_xxtea_block_cipher.sv
// Self-checking testbench for the XXTEA block cipher with a block predictor.
`timescale 1ns / 1ps

class cipher_ledger;
    typedef struct {
        logic [31:0] word;
        logic        last;
    } cipher_word_t;

    logic [31:0]  key_words[4];
    logic [4:0]   block_len;
    logic         decrypt;
    logic [31:0]  block_words[xxtea_pkg::MAX_BLOCK_WORDS_DEF];
    int unsigned  words_held;
    cipher_word_t expected_words[$];
    int unsigned  errors;

    function new();
        foreach (key_words[i]) key_words[i] = '0;
        foreach (block_words[i]) block_words[i] = '0;
        block_len  = xxtea_pkg::BLEN_RESET;
        decrypt    = 1'b0;
        words_held = 0;
        errors     = 0;
    endfunction

    function logic [31:0] mix_word(logic [31:0] y, logic [31:0] z, logic [31:0] sum,
                                   logic [31:0] k);
        return (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^ ((sum ^ y) + (k ^ z));
    endfunction

    function int unsigned block_size();
        int unsigned n;
        n = block_len;
        if (n < 2) n = 2;
        if (n > xxtea_pkg::MAX_BLOCK_WORDS_DEF) n = xxtea_pkg::MAX_BLOCK_WORDS_DEF;
        return n;
    endfunction

    function void note_config(logic [2:0] idx, logic [31:0] value);
        case (idx)
            xxtea_pkg::CFG_KEY0:    key_words[0] = value;
            xxtea_pkg::CFG_KEY1:    key_words[1] = value;
            xxtea_pkg::CFG_KEY2:    key_words[2] = value;
            xxtea_pkg::CFG_KEY3:    key_words[3] = value;
            xxtea_pkg::CFG_BLEN:    block_len = value[4:0];
            xxtea_pkg::CFG_DECRYPT: decrypt = value[0];
            default: ;
        endcase
    endfunction

    function void encipher_words(int unsigned n);
        int unsigned rounds;
        logic [31:0] z;
        logic [31:0] sum;
        logic [1:0]  e;
        rounds = 6 + 52 / n;
        z      = block_words[n-1];
        sum    = '0;
        for (int unsigned r = 0; r < rounds; r++) begin
            sum = sum + xxtea_pkg::XXTEA_DELTA;
            e   = sum[3:2];
            for (int unsigned p = 0; p + 1 < n; p++) begin
                block_words[p] = block_words[p] +
                    mix_word(block_words[p+1], z, sum, key_words[(p & 3) ^ e]);
                z = block_words[p];
            end
            block_words[n-1] = block_words[n-1] +
                mix_word(block_words[0], z, sum, key_words[((n - 1) & 3) ^ e]);
            z = block_words[n-1];
        end
    endfunction

    function void decipher_words(int unsigned n);
        int unsigned rounds;
        logic [31:0] y;
        logic [31:0] sum;
        logic [1:0]  e;
        rounds = 6 + 52 / n;
        y      = block_words[0];
        sum    = 32'(rounds) * xxtea_pkg::XXTEA_DELTA;
        for (int unsigned r = 0; r < rounds; r++) begin
            e = sum[3:2];
            for (int unsigned p = n - 1; p > 0; p--) begin
                block_words[p] = block_words[p] -
                    mix_word(y, block_words[p-1], sum, key_words[(p & 3) ^ e]);
                y = block_words[p];
            end
            block_words[0] = block_words[0] - mix_word(y, block_words[n-1], sum, key_words[e]);
            y   = block_words[0];
            sum = sum - xxtea_pkg::XXTEA_DELTA;
        end
    endfunction

    function void note_word(logic [31:0] w);
        int unsigned  n;
        cipher_word_t cw;
        n = block_size();
        if (words_held < xxtea_pkg::MAX_BLOCK_WORDS_DEF) block_words[words_held] = w;
        words_held++;
        if (words_held < n) return;
        words_held = 0;
        if (decrypt) decipher_words(n);
        else encipher_words(n);
        for (int unsigned i = 0; i < n; i++) begin
            cw.word = block_words[i];
            cw.last = (i + 1 == n);
            expected_words.push_back(cw);
        end
    endfunction

    function void check_word(logic [31:0] word, logic last);
        cipher_word_t want;
        if (expected_words.size() == 0) begin
            $error("result_word: expected none, actual %h", word);
            errors++;
            return;
        end
        want = expected_words.pop_front();
        if (word !== want.word) begin
            $error("result_word: expected %h, actual %h", want.word, word);
            errors++;
        end
        if (last !== want.last) begin
            $error("last_word: expected %b, actual %b", want.last, last);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return expected_words.size();
    endfunction
endclass

module tb_xxtea_block_cipher;
    import xxtea_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE      = 32;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER[6] =
        '{CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3, CFG_BLEN, CFG_DECRYPT};
    localparam logic [BLEN_W-1:0] LEN_EDGES[6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic [WORD_W-1:0]    s_tdata   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY0;
    logic [WORD_W-1:0]    cfg_data  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [WORD_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic                 cfg_ready;

    logic [7:0]  ready_pattern = 8'hff;
    logic [5:0]  pattern_step  = '0;
    int unsigned burst_left    = 0;

    cipher_ledger ledger = new();

    xxtea_block_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        pattern_step <= pattern_step + 6'd1;
        m_tready     <= ready_pattern[pattern_step[2:0]];
        if (pattern_step == 6'd63) begin
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.check_word(m_tdata, m_tlast);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("xxtea_block_cipher regression: fail");
        $finish;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic new_setting(input logic [31:0] keys[4], input logic [4:0] len,
                               input logic dec, input logic [5:0] write_mask);
        logic [31:0] values[6];
        values[0] = keys[0];
        values[1] = keys[1];
        values[2] = keys[2];
        values[3] = keys[3];
        values[4] = 32'(len);
        values[5] = 32'(dec);
        for (int i = 0; i < 6; i++) begin
            if (write_mask[i]) begin
                cfg_valid <= 1'b1;
                cfg_index <= REG_ORDER[i];
                cfg_data  <= values[i];
                do @(posedge aclk); while (!cfg_ready);
                ledger.note_config(REG_ORDER[i], values[i]);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [31:0] w);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        ledger.note_word(w);
        burst_left--;
    endtask

    // hold off until every expected word is out and the core is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] keys[4];
        logic [4:0]  len;
        logic [5:0]  mask;
        int unsigned n;
        int unsigned random_words;
        int unsigned phase;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset key and direction, shortest block
        keys = '{32'h0, 32'h0, 32'h0, 32'h0};
        new_setting(keys, 5'd2, 1'b0, 6'b010000);
        send_word(32'h0000_0000);
        send_word(32'h0000_0000);
        drain();

        // all-ones key, length below range
        keys = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        new_setting(keys, 5'd0, 1'b0, 6'b011111);
        send_word(32'hffff_ffff);
        send_word(32'hffff_ffff);
        drain();

        foreach (keys[i]) keys[i] = $urandom;
        new_setting(keys, 5'd1, 1'b1, 6'b111111);
        send_word(32'h0000_0000);
        send_word(32'hffff_ffff);
        drain();

        foreach (keys[i]) keys[i] = $urandom;
        new_setting(keys, 5'd3, 1'b0, 6'b111111);
        repeat (3) send_word($urandom);
        drain();

        // length above range, then lowered with key and direction changed mid-block
        new_setting(keys, 5'd17, 1'b0, 6'b110000);
        repeat (4) send_word($urandom);
        drain();
        foreach (keys[i]) keys[i] = $urandom;
        new_setting(keys, 5'd2, 1'b1, 6'b111111);
        send_word($urandom);
        drain();

        random_words = 0;
        phase        = 0;
        while (random_words < 70) begin
            foreach (keys[i]) keys[i] = pick_word();
            if (phase == 0) len = 5'd31;
            else if ($urandom_range(0, 3) == 0) len = LEN_EDGES[$urandom_range(0, 5)];
            else len = 5'($urandom_range(2, 16));
            mask = (phase == 0) ? 6'b111111 : (6'($urandom) | 6'b010000);
            new_setting(keys, len, 1'($urandom_range(0, 1)), mask);
            n = ledger.block_size();
            repeat ($urandom_range(1, 3) * n) begin
                send_word(pick_word());
                random_words++;
            end
            // leave a partial block behind for the next setting
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, n - 1)) begin
                    send_word(pick_word());
                    random_words++;
                end
            end
            drain();
            phase++;
        end

        if (ledger.errors == 0) begin
            $display("xxtea_block_cipher regression: pass");
        end else begin
            $display("xxtea_block_cipher regression: fail");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/xxtea_pkg.sv
design/xxtea_ram.sv
design/xxtea_block_cipher.sv
sim/tb_xxtea_block_cipher.sv
